// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
// Needs clk and arst_n visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock, held off during reset.
`define UWBF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define UWBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/uwbf_pkg.sv -----
// Shared types and constants of the follow speed controller.
// No dependencies; used by the divider, the controller core and the bench.
package uwbf_pkg;

	localparam int SPEED_FRAC_BITS = 10;

	localparam int PADDR_W = 5;
	localparam int MUL_W   = 53;	// widest product: Q16 speed times squared range
	localparam int MULB_W  = 25;	// widest serial multiplier operand
	localparam int DIV_NW  = 54;
	localparam int DIV_DW  = 32;
	localparam int DIV_QW  = 15;	// quotients beyond this only saturate
	localparam int DIV_CW  = $clog2(DIV_QW + 1);

	localparam logic [DIV_DW-1:0] DEN_FWD  = DIV_DW'(15625 << (22 - SPEED_FRAC_BITS));
	localparam logic [DIV_DW-1:0] DEN_TURN = DIV_DW'(10000000);
	localparam logic [DIV_DW-1:0] DEN_TEN  = DIV_DW'(10);
	localparam logic [MUL_W-1:0]  MILLION  = MUL_W'(1000000);
	localparam logic [25:0]       Q_OFFSET = 26'd3000000;
	localparam logic [12:0]       AZ_BIAS  = 13'd2000;
	localparam logic [27:0]       IDLE_WALK_Q16 = 28'(120 << 16);
	localparam logic [11:0]       MIN_TURN_RANGE = 12'd10;
	localparam logic [18:0]       TURN_SMOOTH_BIAS = 19'd81925;
	localparam logic [14:0]       TURN_SMOOTH_OFFS = 15'd8192;

	typedef enum logic [2:0] {
		REG_MIN_FOLLOW = 3'd0,
		REG_STOP_DIST  = 3'd1,
		REG_LOST_DIST  = 3'd2,
		REG_MAX_LOST   = 3'd3,
		REG_MIN_TURN   = 3'd4,
		REG_TARGET_AZ  = 3'd5,
		REG_MAX_FWD    = 3'd6,
		REG_MAX_TURN   = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_EVAL, ST_SQ_VX, ST_SQ_VY, ST_SQRT, ST_FWD, ST_MUL_PP, ST_MUL_HP,
		ST_DIV_F, ST_TURN, ST_MUL_Q, ST_MUL_VQ, ST_MUL_DEN, ST_DIV_T, ST_SMOOTH,
		ST_SM_F, ST_SM_T, ST_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

	typedef struct packed {
		logic        latch;
		logic [13:0] val;
	} sat_t;

endpackage

// ----- rtl/core/uwbf_div.sv -----
// Shared restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on uwbf_pkg.
module uwbf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [uwbf_pkg::DIV_NW-1:0]   num,
	input  logic [uwbf_pkg::DIV_DW-1:0]   den,
	output uwbf_pkg::div_stat_t           stat,
	output logic [uwbf_pkg::DIV_QW-1:0]   quo
);
	localparam int NW = uwbf_pkg::DIV_NW;
	localparam int DW = uwbf_pkg::DIV_DW;
	localparam int QW = uwbf_pkg::DIV_QW;
	localparam int CW = uwbf_pkg::DIV_CW;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] low_q;
	logic [QW-1:0] quo_q;
	logic [DW:0]   trial;
	logic          ge;
	logic          ovf_in;

	// quotient of 2^QW or more only matters as "too big"
	assign ovf_in = num[NW-1:QW] >= (NW-QW)'(den);
	assign trial  = {rem_q, low_q[QW-1]};
	assign ge     = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ovf_in ? '0 : CW'(QW);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= ovf_in;
			den_q <= den;
			rem_q <= num[QW+DW-1:QW];
			low_q <= num[QW-1:0];
			quo_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
			low_q <= {low_q[QW-2:0], 1'b0};
		end
	end

	assign stat.done = busy_q && (cnt_q == '0);
	assign stat.ovf  = ovf_q;
	assign quo       = quo_q;

endmodule

// ----- rtl/core/uwb_follow_speed_controller_core.sv -----
// Follow speed controller: one result per ranging fix, one request at a time. A lost fix
// or a target outside the working range goes from the evaluation state straight to the
// result state. A full fix runs a bit-serial shift-add multiplier (one multiplier bit
// per cycle), a 28-step square root and a 15-step divider shared by the forward, turn
// and smoothing divisions; the multiplier ends a product once its remaining multiplier
// bits are zero. A stalled result holds the block in its last state, and the next
// request is taken in the cycle after the result enters the output register.
// Depends on uwbf_pkg and uwbf_div.
module uwb_follow_speed_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [uwbf_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          fix_valid,
	input  logic [11:0]                   range_cm,
	input  logic [11:0]                   azimuth_tenths,
	input  logic signed [11:0]            vel_x,
	input  logic signed [11:0]            vel_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          move_cmd,
	output logic                          following,
	output logic [13:0]                   forward_speed,
	output logic signed [12:0]            turn_speed
);
	localparam int F  = uwbf_pkg::SPEED_FRAC_BITS;
	localparam int MW = uwbf_pkg::MUL_W;
	localparam int BW = uwbf_pkg::MULB_W;
	localparam int NW = uwbf_pkg::DIV_NW;
	localparam int DW = uwbf_pkg::DIV_DW;
	localparam int QW = uwbf_pkg::DIV_QW;

	// configuration
	logic [11:0] min_follow_q, stop_dist_q, lost_dist_q, target_az_q, max_turn_q;
	logic [7:0]  max_lost_q;
	logic [10:0] min_turn_q;
	logic [13:0] max_fwd_q;

	// captured request
	logic              fix_q;
	logic [11:0]       range_q, az_q;
	logic signed [11:0] vx_q, vy_q;

	// persistent state
	logic [7:0]        lost_cnt_q;
	logic              follow_q, fwd_max_q, turn_max_q, first_q;
	logic [13:0]       prev_fwd_q;
	logic signed [12:0] prev_turn_q;

	// working registers
	uwbf_pkg::state_t state_q, state_d;
	logic [MW-1:0] mul_a_q, mul_acc_q;
	logic [BW-1:0] mul_b_q;
	logic          mul_done;
	logic [23:0]   s_q, sq_rad_q;
	logic [31:0]   sq_rem_q;
	logic [27:0]   sq_root_q, hq_q;
	logic [4:0]    sq_cnt_q;
	logic [13:0]   fwd_q, sfwd_q;
	logic signed [12:0] turn_q;
	logic [36:0]   vq_q;

	// pending result and output register
	logic              res_move_q, res_follow_q;
	logic [13:0]       res_fwd_q;
	logic signed [12:0] res_turn_q;
	logic              out_valid_q;

	// control to shared units
	logic          mul_load;
	logic [MW-1:0] mul_a_ld;
	logic [BW-1:0] mul_b_ld;
	logic          div_start;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	uwbf_pkg::div_stat_t div_st;
	logic [QW-1:0] div_quo;

	// derived values
	logic signed [12:0] adiff, adiff_neg;
	logic        pos, vx_pos, vy_pos, d_gt_min, a_gt_min, out_range, too_near;
	logic        near_f, near_t, lost_stop, wr_en, take_out;
	logic [11:0] a_mag, abs_vx;
	logic [12:0] p_val;
	logic [25:0] q_val;
	logic [31:0] sq_t, sq_trial, sq_rem_nxt;
	logic [27:0] sq_root_nxt;
	logic        sq_ge;
	logic [17:0] fnum;
	logic signed [18:0] tnum;
	logic [14:0] sturn_w;
	uwbf_pkg::sat_t sat_f, sat_t0, sat_td;

	function automatic uwbf_pkg::sat_t saturate(input logic [QW-1:0] raw, input logic ovf,
			input logic [13:0] lim, input logic latch, input logic near);
		uwbf_pkg::sat_t r;
		r.val   = raw[13:0];
		r.latch = latch;
		if (ovf || raw > {1'b0, lim}) begin
			r.val   = lim;
			r.latch = 1'b1;
		end else if (latch) begin
			if (near)
				r.latch = 1'b0;
			else
				r.val = lim;
		end
		return r;
	endfunction

	assign adiff     = $signed({1'b0, az_q}) - $signed({1'b0, target_az_q});
	assign adiff_neg = -adiff;
	assign pos       = !adiff[12];
	assign a_mag     = pos ? adiff[11:0] : adiff_neg[11:0];
	assign a_gt_min  = a_mag > 12'(min_turn_q);
	assign abs_vx    = vx_q[11] ? 12'(-vx_q) : vx_q;
	assign vx_pos    = !vx_q[11] && (vx_q != '0);
	assign vy_pos    = !vy_q[11] && (vy_q != '0);
	assign d_gt_min  = range_q > min_follow_q;
	assign p_val     = 13'(range_q) - 13'(min_follow_q) + 13'd100;
	assign too_near  = range_q < stop_dist_q;
	assign out_range = too_near || (range_q > lost_dist_q);
	assign near_f    = (16'(range_q) * 16'd10) < (16'(min_follow_q) * 16'd11);
	assign near_t    = (16'(a_mag) * 16'd10) < (16'(min_turn_q) * 16'd11);
	assign lost_stop = lost_cnt_q >= max_lost_q;
	assign q_val     = 26'(mul_acc_q) - uwbf_pkg::Q_OFFSET;
	assign mul_done  = (mul_b_q == '0);

	// one root bit per cycle
	assign sq_t        = {sq_rem_q[29:0], sq_rad_q[23:22]};
	assign sq_trial    = {2'b00, sq_root_q, 2'b01};
	assign sq_ge       = sq_t >= sq_trial;
	assign sq_rem_nxt  = sq_ge ? sq_t - sq_trial : sq_t;
	assign sq_root_nxt = {sq_root_q[26:0], sq_ge};

	// smoothing numerators; the turn one is biased to stay positive
	assign fnum = 18'(fwd_q) * 18'd3 + 18'(prev_fwd_q) * 18'd7 + 18'd5;
	assign tnum = (19'(turn_q) <<< 2) + 19'(prev_turn_q) * 19'sd6
		+ $signed(uwbf_pkg::TURN_SMOOTH_BIAS);
	assign sturn_w = div_quo - uwbf_pkg::TURN_SMOOTH_OFFS;

	assign sat_f  = saturate(div_quo, div_st.ovf, max_fwd_q, fwd_max_q, near_f);
	assign sat_t0 = saturate('0, 1'b0, {2'b00, max_turn_q}, turn_max_q, near_t);
	assign sat_td = saturate(div_quo, div_st.ovf, {2'b00, max_turn_q}, turn_max_q, near_t);

	assign in_stall = (state_q != uwbf_pkg::ST_IDLE);
	assign take_out = !out_valid_q || !out_stall;

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_follow_q <= 12'd250;
			stop_dist_q  <= 12'd100;
			lost_dist_q  <= 12'd1000;
			max_lost_q   <= 8'd30;
			min_turn_q   <= 11'd35;
			target_az_q  <= 12'd900;
			max_fwd_q    <= 14'd5120;
			max_turn_q   <= 12'd1024;
		end else if (wr_en) begin
			unique case (uwbf_pkg::reg_idx_t'(paddr[4:2]))
				uwbf_pkg::REG_MIN_FOLLOW: min_follow_q <= pwdata[11:0];
				uwbf_pkg::REG_STOP_DIST:  stop_dist_q  <= pwdata[11:0];
				uwbf_pkg::REG_LOST_DIST:  lost_dist_q  <= pwdata[11:0];
				uwbf_pkg::REG_MAX_LOST:   max_lost_q   <= pwdata[7:0];
				uwbf_pkg::REG_MIN_TURN:   min_turn_q   <= pwdata[10:0];
				uwbf_pkg::REG_TARGET_AZ:  target_az_q  <= pwdata[11:0];
				uwbf_pkg::REG_MAX_FWD:    max_fwd_q    <= pwdata[13:0];
				uwbf_pkg::REG_MAX_TURN:   max_turn_q   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (uwbf_pkg::reg_idx_t'(paddr[4:2]))
			uwbf_pkg::REG_MIN_FOLLOW: prdata = 32'(min_follow_q);
			uwbf_pkg::REG_STOP_DIST:  prdata = 32'(stop_dist_q);
			uwbf_pkg::REG_LOST_DIST:  prdata = 32'(lost_dist_q);
			uwbf_pkg::REG_MAX_LOST:   prdata = 32'(max_lost_q);
			uwbf_pkg::REG_MIN_TURN:   prdata = 32'(min_turn_q);
			uwbf_pkg::REG_TARGET_AZ:  prdata = 32'(target_az_q);
			uwbf_pkg::REG_MAX_FWD:    prdata = 32'(max_fwd_q);
			uwbf_pkg::REG_MAX_TURN:   prdata = 32'(max_turn_q);
			default:                  prdata = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			uwbf_pkg::ST_IDLE:    if (in_valid) state_d = uwbf_pkg::ST_EVAL;
			uwbf_pkg::ST_EVAL: begin
				if (!fix_q || out_range)
					state_d = uwbf_pkg::ST_DONE;
				else if (vy_pos)
					state_d = uwbf_pkg::ST_SQ_VX;
				else
					state_d = uwbf_pkg::ST_FWD;
			end
			uwbf_pkg::ST_SQ_VX:   if (mul_done) state_d = uwbf_pkg::ST_SQ_VY;
			uwbf_pkg::ST_SQ_VY:   if (mul_done) state_d = uwbf_pkg::ST_SQRT;
			uwbf_pkg::ST_SQRT:    if (sq_cnt_q == '0) state_d = uwbf_pkg::ST_FWD;
			uwbf_pkg::ST_FWD:
				state_d = d_gt_min ? uwbf_pkg::ST_MUL_PP : uwbf_pkg::ST_TURN;
			uwbf_pkg::ST_MUL_PP:  if (mul_done) state_d = uwbf_pkg::ST_MUL_HP;
			uwbf_pkg::ST_MUL_HP:  if (mul_done) state_d = uwbf_pkg::ST_DIV_F;
			uwbf_pkg::ST_DIV_F:   if (div_st.done) state_d = uwbf_pkg::ST_TURN;
			uwbf_pkg::ST_TURN:
				state_d = a_gt_min ? uwbf_pkg::ST_MUL_Q : uwbf_pkg::ST_SMOOTH;
			uwbf_pkg::ST_MUL_Q: begin
				if (mul_done) begin
					priority if (range_q <= uwbf_pkg::MIN_TURN_RANGE)
						state_d = uwbf_pkg::ST_SMOOTH;
					else if (vx_pos != pos)
						state_d = uwbf_pkg::ST_DIV_T;
					else
						state_d = uwbf_pkg::ST_MUL_VQ;
				end
			end
			uwbf_pkg::ST_MUL_VQ:  if (mul_done) state_d = uwbf_pkg::ST_MUL_DEN;
			uwbf_pkg::ST_MUL_DEN: if (mul_done) state_d = uwbf_pkg::ST_DIV_T;
			uwbf_pkg::ST_DIV_T:   if (div_st.done) state_d = uwbf_pkg::ST_SMOOTH;
			uwbf_pkg::ST_SMOOTH:
				state_d = first_q ? uwbf_pkg::ST_DONE : uwbf_pkg::ST_SM_F;
			uwbf_pkg::ST_SM_F:    if (div_st.done) state_d = uwbf_pkg::ST_SM_T;
			uwbf_pkg::ST_SM_T:    if (div_st.done) state_d = uwbf_pkg::ST_DONE;
			uwbf_pkg::ST_DONE:    if (take_out) state_d = uwbf_pkg::ST_IDLE;
			default:              state_d = uwbf_pkg::ST_IDLE;
		endcase
	end

	// operand loads for the multiplier and divider
	always_comb begin
		mul_load  = 1'b0;
		mul_a_ld  = '0;
		mul_b_ld  = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = uwbf_pkg::DEN_TEN;
		unique case (state_q)
			uwbf_pkg::ST_EVAL: begin
				if (fix_q && !out_range && vy_pos) begin
					mul_load = 1'b1;
					mul_a_ld = MW'(abs_vx);
					mul_b_ld = BW'(abs_vx);
				end
			end
			uwbf_pkg::ST_SQ_VX: begin
				if (mul_done) begin
					mul_load = 1'b1;
					mul_a_ld = MW'(unsigned'(vy_q));
					mul_b_ld = BW'(unsigned'(vy_q));
				end
			end
			uwbf_pkg::ST_FWD: begin
				if (d_gt_min) begin
					mul_load = 1'b1;
					mul_a_ld = MW'(p_val);
					mul_b_ld = BW'(p_val);
				end
			end
			uwbf_pkg::ST_MUL_PP: begin
				if (mul_done) begin
					mul_load = 1'b1;
					mul_a_ld = MW'(hq_q);
					mul_b_ld = mul_acc_q[BW-1:0];
				end
			end
			uwbf_pkg::ST_MUL_HP: begin
				if (mul_done) begin
					div_start = 1'b1;
					div_num   = NW'(mul_acc_q);
					div_den   = uwbf_pkg::DEN_FWD;
				end
			end
			uwbf_pkg::ST_TURN: begin
				if (a_gt_min) begin
					mul_load = 1'b1;
					mul_a_ld = MW'(13'(a_mag) + uwbf_pkg::AZ_BIAS);
					mul_b_ld = BW'(13'(a_mag) + uwbf_pkg::AZ_BIAS);
				end
			end
			uwbf_pkg::ST_MUL_Q: begin
				if (mul_done && range_q > uwbf_pkg::MIN_TURN_RANGE) begin
					if (vx_pos != pos) begin
						// person's rate fixed at 0.4 rad/s
						div_start = 1'b1;
						div_num   = NW'({q_val, 2'b00}) << F;
						div_den   = uwbf_pkg::DEN_TURN;
					end else begin
						mul_load = 1'b1;
						mul_a_ld = MW'(q_val);
						mul_b_ld = BW'(abs_vx);
					end
				end
			end
			uwbf_pkg::ST_MUL_VQ: begin
				if (mul_done) begin
					mul_load = 1'b1;
					mul_a_ld = uwbf_pkg::MILLION;
					mul_b_ld = BW'(range_q);
				end
			end
			uwbf_pkg::ST_MUL_DEN: begin
				if (mul_done) begin
					div_start = 1'b1;
					div_num   = NW'(vq_q) << F;
					div_den   = mul_acc_q[DW-1:0];
				end
			end
			uwbf_pkg::ST_SMOOTH: begin
				if (!first_q) begin
					div_start = 1'b1;
					div_num   = NW'(fnum);
				end
			end
			uwbf_pkg::ST_SM_F: begin
				if (div_st.done) begin
					div_start = 1'b1;
					div_num   = NW'(unsigned'(tnum));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= uwbf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// shift-add multiplier, one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_b_q <= '0;
		end else if (mul_load) begin
			mul_b_q <= mul_b_ld;
		end else if (!mul_done) begin
			mul_b_q <= mul_b_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_load) begin
			mul_a_q   <= mul_a_ld;
			mul_acc_q <= '0;
		end else if (!mul_done) begin
			if (mul_b_q[0])
				mul_acc_q <= mul_acc_q + mul_a_q;
			mul_a_q <= mul_a_q << 1;
		end
	end

	uwbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_st),
		.quo    (div_quo)
	);

	// request capture and working registers
	always_ff @(posedge clk) begin
		if (state_q == uwbf_pkg::ST_IDLE && in_valid) begin
			fix_q   <= fix_valid;
			range_q <= range_cm;
			az_q    <= azimuth_tenths;
			vx_q    <= vel_x;
			vy_q    <= vel_y;
		end
		if (state_q == uwbf_pkg::ST_EVAL && !vy_pos)
			hq_q <= uwbf_pkg::IDLE_WALK_Q16;
		if (state_q == uwbf_pkg::ST_SQ_VX && mul_done)
			s_q <= 24'(mul_acc_q);
		if (state_q == uwbf_pkg::ST_SQ_VY && mul_done) begin
			sq_rad_q  <= s_q + 24'(mul_acc_q);
			sq_rem_q  <= '0;
			sq_root_q <= '0;
			sq_cnt_q  <= 5'd27;
		end
		if (state_q == uwbf_pkg::ST_SQRT) begin
			sq_rad_q  <= {sq_rad_q[21:0], 2'b00};
			sq_rem_q  <= sq_rem_nxt;
			sq_root_q <= sq_root_nxt;
			sq_cnt_q  <= sq_cnt_q - 1'b1;
			if (sq_cnt_q == '0)
				hq_q <= sq_root_nxt;
		end
		if (state_q == uwbf_pkg::ST_FWD && !d_gt_min)
			fwd_q <= '0;
		if (state_q == uwbf_pkg::ST_DIV_F && div_st.done)
			fwd_q <= sat_f.val;
		if (state_q == uwbf_pkg::ST_TURN && !a_gt_min)
			turn_q <= '0;
		if (state_q == uwbf_pkg::ST_MUL_Q && mul_done && range_q <= uwbf_pkg::MIN_TURN_RANGE)
			turn_q <= pos ? $signed(sat_t0.val[12:0]) : -$signed(sat_t0.val[12:0]);
		if (state_q == uwbf_pkg::ST_MUL_VQ && mul_done)
			vq_q <= 37'(mul_acc_q);
		if (state_q == uwbf_pkg::ST_DIV_T && div_st.done)
			turn_q <= pos ? $signed(sat_td.val[12:0]) : -$signed(sat_td.val[12:0]);
		if (state_q == uwbf_pkg::ST_SM_F && div_st.done)
			sfwd_q <= div_quo[13:0];
	end

	// persistent state, pending result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_cnt_q   <= '0;
			follow_q     <= 1'b0;
			fwd_max_q    <= 1'b0;
			turn_max_q   <= 1'b0;
			first_q      <= 1'b1;
			prev_fwd_q   <= '0;
			prev_turn_q  <= '0;
			res_move_q   <= 1'b0;
			res_follow_q <= 1'b0;
			res_fwd_q    <= '0;
			res_turn_q   <= '0;
			out_valid_q  <= 1'b0;
			move_cmd     <= 1'b0;
			following    <= 1'b0;
			forward_speed <= '0;
			turn_speed   <= '0;
		end else begin
			unique case (state_q)
				uwbf_pkg::ST_EVAL: begin
					if (!fix_q) begin
						if (lost_cnt_q != 8'hff)
							lost_cnt_q <= lost_cnt_q + 1'b1;
						if (lost_stop) begin
							follow_q     <= 1'b0;
							res_move_q   <= 1'b0;
							res_follow_q <= 1'b0;
							res_fwd_q    <= '0;
							res_turn_q   <= '0;
						end else begin
							// short loss: repeat last smoothed commands
							res_move_q   <= 1'b1;
							res_follow_q <= follow_q;
							res_fwd_q    <= prev_fwd_q;
							res_turn_q   <= prev_turn_q;
						end
					end else if (out_range) begin
						lost_cnt_q   <= '0;
						follow_q     <= 1'b0;
						fwd_max_q    <= 1'b0;
						turn_max_q   <= 1'b0;
						res_move_q   <= too_near;
						res_follow_q <= 1'b0;
						res_fwd_q    <= '0;
						res_turn_q   <= '0;
					end else begin
						lost_cnt_q <= '0;
						follow_q   <= 1'b1;
					end
				end
				uwbf_pkg::ST_FWD:
					if (!d_gt_min) fwd_max_q <= 1'b0;
				uwbf_pkg::ST_DIV_F:
					if (div_st.done) fwd_max_q <= sat_f.latch;
				uwbf_pkg::ST_TURN:
					if (!a_gt_min) turn_max_q <= 1'b0;
				uwbf_pkg::ST_MUL_Q:
					if (mul_done && range_q <= uwbf_pkg::MIN_TURN_RANGE)
						turn_max_q <= sat_t0.latch;
				uwbf_pkg::ST_DIV_T:
					if (div_st.done) turn_max_q <= sat_td.latch;
				uwbf_pkg::ST_SMOOTH: begin
					if (first_q) begin
						first_q      <= 1'b0;
						prev_fwd_q   <= fwd_q;
						prev_turn_q  <= turn_q;
						res_move_q   <= 1'b1;
						res_follow_q <= 1'b1;
						res_fwd_q    <= fwd_q;
						res_turn_q   <= turn_q;
					end
				end
				uwbf_pkg::ST_SM_T: begin
					if (div_st.done) begin
						prev_fwd_q   <= sfwd_q;
						prev_turn_q  <= $signed(sturn_w[12:0]);
						res_move_q   <= 1'b1;
						res_follow_q <= 1'b1;
						res_fwd_q    <= sfwd_q;
						res_turn_q   <= $signed(sturn_w[12:0]);
					end
				end
				default: ;
			endcase

			if (state_q == uwbf_pkg::ST_DONE && take_out) begin
				out_valid_q   <= 1'b1;
				move_cmd      <= res_move_q;
				following     <= res_follow_q;
				forward_speed <= res_fwd_q;
				turn_speed    <= res_turn_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/uwbf_checker.sv -----
// Port-level checks on the follow speed controller, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module uwbf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pready,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          move_cmd,
	input logic                          following,
	input logic [13:0]                   forward_speed,
	input logic signed [12:0]            turn_speed
);
	logic        stop_clean;
	logic [28:0] res_bus;

	// a stop result carries no commands
	assign stop_clean = move_cmd ||
		(!following && forward_speed == '0 && turn_speed == '0);
	assign res_bus    = {move_cmd, following, forward_speed, turn_speed};

	`UWBF_ASSERT(a_pready_high, pready, "pready dropped")
	`UWBF_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "busy flag missing")
	`UWBF_ASSERT(a_stop_zero, !out_valid || stop_clean, "stop result with nonzero commands")
	`UWBF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`UWBF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(res_bus), "stalled result changed")

endmodule

bind uwb_follow_speed_controller_core uwbf_checker u_uwbf_checker (.*);

// ----- dv/uwb_follow_speed_controller_core_tb.sv -----
// Self-checking bench for uwb_follow_speed_controller_core: random and directed fixes,
// register sweeps over the APB port, each result checked against an in-bench prediction.
// Depends on uwbf_pkg and the core RTL.
module uwb_follow_speed_controller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        fv;
		logic [11:0] rng;
		logic [11:0] az;
		logic [11:0] vx;
		logic [11:0] vy;
	} fix_t;

	typedef struct {
		logic        mv;
		logic        fol;
		logic [13:0] fwd;
		logic [12:0] trn;
	} cmd_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [uwbf_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic fix_valid = 0;
	logic [11:0] range_cm = '0, azimuth_tenths = '0, vel_x = '0, vel_y = '0;
	logic out_valid, out_stall = 0;
	logic move_cmd, following;
	logic [13:0] forward_speed;
	logic signed [12:0] turn_speed;

	uwb_follow_speed_controller_core u_top (.*);

	initial forever #6 clk = ~clk;

	// predictor state and registers
	longint r_minf, r_stop, r_lost, r_maxlost, r_mint, r_taz, r_maxf, r_maxt;
	longint lost_cnt, prev_f, prev_t;
	bit act, f_lat, t_lat, first;

	fix_t pending[$];
	cmd_t expected_cmds[$];
	int idle_pct = 0, stall_pct = 0;
	int n_err = 0, n_cmds = 0, n_sent = 0;

	function automatic longint sqrt_q(longint unsigned v);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic cmd_t predict_cmd(fix_t f);
		cmd_t c;
		longint d, az, vx, vy, adiff, a, trn, sf, st, p, q;
		longint unsigned hq, fwd, w;
		bit pos, stop;
		d = f.rng; az = f.az;
		vx = longint'($signed(f.vx)); vy = longint'($signed(f.vy));
		fwd = 0; w = 0; trn = 0;
		c = '{1'b0, 1'b0, 14'd0, 13'd0};
		if (!f.fv) begin
			stop = lost_cnt >= r_maxlost;
			if (lost_cnt < 255) lost_cnt++;
			if (stop) act = 0;
			else c = '{1'b1, act, prev_f[13:0], prev_t[12:0]};
			return c;
		end
		lost_cnt = 0;
		if (d < r_stop || d > r_lost) begin
			c.mv = d < r_stop;
			act = 0; f_lat = 0; t_lat = 0;
			return c;
		end
		act = 1;
		if (vy > 0) hq = sqrt_q(longint'(vx * vx + vy * vy) << 32);
		else hq = 120 << 16;
		if (d > r_minf) begin
			p = d - r_minf + 100;
			fwd = (hq * p * p) / (15625 << (22 - uwbf_pkg::SPEED_FRAC_BITS));
			if (fwd > r_maxf) begin
				fwd = r_maxf; f_lat = 1;
			end else if (f_lat) begin
				if (10 * d < 11 * r_minf) f_lat = 0;
				else fwd = r_maxf;
			end
		end else f_lat = 0;
		adiff = az - r_taz;
		pos = adiff >= 0;
		a = pos ? adiff : -adiff;
		if (a > r_mint) begin
			q = a * a + 4000 * a + 1000000;
			if (d > 10) begin
				if ((vx > 0) != pos)
					w = ((4 * q) << uwbf_pkg::SPEED_FRAC_BITS) / 10000000;
				else
					w = (((vx < 0 ? -vx : vx) * q) << uwbf_pkg::SPEED_FRAC_BITS)
						/ (d * 1000000);
			end
			if (w > r_maxt) begin
				w = r_maxt; t_lat = 1;
			end else if (t_lat) begin
				if (10 * a < 11 * r_mint) t_lat = 0;
				else w = r_maxt;
			end
			trn = pos ? longint'(w) : -longint'(w);
		end else t_lat = 0;
		if (first) begin
			sf = fwd; st = trn; first = 0;
		end else begin
			sf = (3 * longint'(fwd) + 7 * prev_f + 5) / 10;
			st = (4 * trn + 6 * prev_t + 5 + 81920) / 10 - 8192;
		end
		prev_f = sf; prev_t = st;
		c = '{1'b1, 1'b1, sf[13:0], st[12:0]};
		return c;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_valid) begin
				expected_cmds.push_back(predict_cmd('{fix_valid, range_cm, azimuth_tenths,
					vel_x, vel_y}));
				n_sent++;
			end
			if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
				fix_t f;
				f = pending.pop_front();
				in_valid <= 1;
				fix_valid <= f.fv; range_cm <= f.rng; azimuth_tenths <= f.az;
				vel_x <= f.vx; vel_y <= f.vy;
			end else in_valid <= 0;
		end
		if (arst_n) out_stall <= $urandom_range(99) < stall_pct;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			cmd_t e;
			n_cmds++;
			if (expected_cmds.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected command mv=%0b fwd=%0d", move_cmd,
					forward_speed);
			end else begin
				e = expected_cmds.pop_front();
				if (e.mv !== move_cmd || e.fol !== following || e.fwd !== forward_speed
					|| e.trn !== turn_speed) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp mv=%0b fol=%0b fwd=%0d trn=%0d, got %0b %0b %0d %0d",
							e.mv, e.fol, e.fwd, $signed(e.trn), move_cmd, following,
							forward_speed, turn_speed);
				end
			end
		end
	end

	task automatic write_reg(uwbf_pkg::reg_idx_t idx, longint v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= uwbf_pkg::PADDR_W'(4 * idx);
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			uwbf_pkg::REG_MIN_FOLLOW: r_minf = v & 12'hfff;
			uwbf_pkg::REG_STOP_DIST:  r_stop = v & 12'hfff;
			uwbf_pkg::REG_LOST_DIST:  r_lost = v & 12'hfff;
			uwbf_pkg::REG_MAX_LOST:   r_maxlost = v & 8'hff;
			uwbf_pkg::REG_MIN_TURN:   r_mint = v & 11'h7ff;
			uwbf_pkg::REG_TARGET_AZ:  r_taz = v & 12'hfff;
			uwbf_pkg::REG_MAX_FWD:    r_maxf = v & 14'h3fff;
			default:                  r_maxt = v & 12'hfff;
		endcase
	endtask

	task automatic add_fix(bit fv, int rng, int az, int vx, int vy);
		pending.push_back('{fv, 12'(rng), 12'(az), 12'(vx), 12'(vy)});
	endtask

	// mostly valid fixes in the working range, some noise
	task automatic add_random(int n);
		repeat (n) begin
			int k;
			k = $urandom_range(99);
			if (k < 70)
				add_fix(1, $urandom_range(r_lost > 4095 ? 4095 : r_lost, r_stop),
					$urandom_range(3600), $urandom_range(4095), $urandom_range(4095));
			else if (k < 85)
				add_fix(0, $urandom, $urandom, $urandom, $urandom);
			else
				add_fix(1, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic drain;
		while (pending.size() > 0 || in_valid || expected_cmds.size() > 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	initial begin
		r_minf = 250; r_stop = 100; r_lost = 1000; r_maxlost = 30;
		r_mint = 35; r_taz = 900; r_maxf = 5120; r_maxt = 1024;
		lost_cnt = 0; act = 0; f_lat = 0; t_lat = 0; prev_f = 0; prev_t = 0; first = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, loss cases, near/far, latches, turn sides
		add_fix(1, 500, 900, 0, 0);
		add_fix(1, 1000, 3600, 2047, 2047);
		add_fix(1, 999, 0, -2048, 2047);
		add_fix(1, 300, 1000, 100, 50);
		add_fix(1, 270, 850, -100, -2048);
		add_fix(1, 260, 2000, 5, 1);
		repeat (3) add_fix(0, 4095, 4095, 2047, 2047);
		add_fix(1, 50, 900, 0, 10);
		add_fix(1, 4095, 4095, 0, 0);
		add_fix(1, 10, 900, 0, 0);
		add_fix(1, 100, 2000, 1, 1);
		add_fix(1, 11, 2000, 300, 1);
		repeat (4) add_fix(0, 0, 0, 0, 0);
		drain();
		write_reg(uwbf_pkg::REG_MAX_LOST, 0);
		add_fix(0, 0, 0, 0, 0);
		add_fix(1, 600, 900, 0, 200);
		drain();
		write_reg(uwbf_pkg::REG_MIN_FOLLOW, 0); write_reg(uwbf_pkg::REG_STOP_DIST, 0);
		write_reg(uwbf_pkg::REG_LOST_DIST, 4095); write_reg(uwbf_pkg::REG_MAX_LOST, 255);
		write_reg(uwbf_pkg::REG_MIN_TURN, 0); write_reg(uwbf_pkg::REG_TARGET_AZ, 0);
		write_reg(uwbf_pkg::REG_MAX_FWD, 16383); write_reg(uwbf_pkg::REG_MAX_TURN, 4095);
		for (int ph = 0; ph < 8; ph++) begin
			idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 26 : 87) : 0;
			stall_pct = (ph % 4 == 2) ? 87 : (ph % 4 == 3 ? 26 : 0);
			if (ph == 4) begin
				write_reg(uwbf_pkg::REG_MIN_FOLLOW, 4095);
				write_reg(uwbf_pkg::REG_STOP_DIST, 4095);
				write_reg(uwbf_pkg::REG_LOST_DIST, 0); write_reg(uwbf_pkg::REG_MAX_LOST, 1);
				write_reg(uwbf_pkg::REG_MIN_TURN, 1800);
				write_reg(uwbf_pkg::REG_TARGET_AZ, 3600);
				write_reg(uwbf_pkg::REG_MAX_FWD, 0); write_reg(uwbf_pkg::REG_MAX_TURN, 0);
			end else if (ph == 5) begin
				write_reg(uwbf_pkg::REG_MIN_FOLLOW, $urandom_range(600));
				write_reg(uwbf_pkg::REG_STOP_DIST, 40);
				write_reg(uwbf_pkg::REG_LOST_DIST, 2500); write_reg(uwbf_pkg::REG_MAX_LOST, 5);
				write_reg(uwbf_pkg::REG_MIN_TURN, 20); write_reg(uwbf_pkg::REG_TARGET_AZ, 1800);
				write_reg(uwbf_pkg::REG_MAX_FWD, 3000); write_reg(uwbf_pkg::REG_MAX_TURN, 500);
			end
			add_random(100);
			drain();
		end
		$display("covered %0d fixes, %0d commands checked, %0d mismatches", n_sent, n_cmds,
			n_err);
		if (n_err == 0 && expected_cmds.size() == 0)
			$display("uwb_follow_speed_controller_core test passed");
		else
			$display("uwb_follow_speed_controller_core test failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("uwb_follow_speed_controller_core test failed");
		$finish;
	end
endmodule
